// File: rtl/ilt_pkg.sv
// ilt_pkg: shared types and constants for the indexed list table.
// Command and status codes, sequencer states, default sizes.
// No dependencies.
package ilt_pkg;

    // default sizing
    localparam int DEF_CAPACITY   = 64;
    localparam int DEF_ENTRY_BITS = 32;

    // stream word widths (fields packed low to high, padded to bytes)
    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 48;

    // list commands
    typedef enum logic [2:0] {
        CMD_GET    = 3'd0,
        CMD_SET    = 3'd1,
        CMD_ADD    = 3'd2,
        CMD_INSERT = 3'd3,
        CMD_REMOVE = 3'd4,
        CMD_CLEAR  = 3'd5
    } t_cmd;

    // result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_READ,
        S_SHIFT,
        S_INS_FINAL,
        S_RESULT
    } t_state;

endpackage

// File: rtl/indexed_list_table.sv
// indexed_list_table: ordered list of references with get/set/add/insert/
// remove/clear, entries kept in a one-write one-read memory.
// Depends on ilt_pkg.
//
//  channel | dir | handshake               | word
//  --------+-----+-------------------------+-------------------------------------
//  s (cmd) | in  | i_s_tvalid / o_s_tready | cmd[2:0] position[9:3] value[41:10]
//  m (res) | out | o_m_tvalid / i_m_tready | status[1:0] read[33:2] newpos[39:34]
//          |     |                         | count[46:40]
//
// One command at a time. Set, add, clear, errors, an insert at the tail and a
// remove of the tail finish in S_CHECK, get reads in S_READ, and any other
// insert or remove walks the entries in S_SHIFT (an insert then writes its
// value in S_INS_FINAL) before S_RESULT; the entry walk moves one entry per cycle
// through the memory's single write port, driven by one shared +/-1 address
// unit. Synchronous active-low reset empties the list; memory is not cleared.
// A result waiting on o_m_tvalid does not block the next command; a second
// result waits in the sequencer until the output register frees up.
module indexed_list_table
    import ilt_pkg::*;
#(
    parameter int CAPACITY   = DEF_CAPACITY,
    parameter int ENTRY_BITS = DEF_ENTRY_BITS
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // command word
    input  logic                   i_s_tvalid,
    output logic                   o_s_tready,
    input  logic [IN_TDATA_W-1:0]  i_s_tdata,  // cmd, position, entry_value, zero pad
    // result word
    output logic                   o_m_tvalid,
    input  logic                   i_m_tready,
    output logic [OUT_TDATA_W-1:0] o_m_tdata   // status, read_value, new_position,
                                               // count_now, zero pad
);

    localparam int IW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int CMPW = (CW > 7) ? CW : 7;

    // entry memory
    logic [ENTRY_BITS-1:0] r_mem [CAPACITY];
    logic [ENTRY_BITS-1:0] r_rd_data;

    // sequencer and command registers
    t_state          r_state, n_state;
    t_cmd            r_cmd, n_cmd;
    logic [6:0]      r_pos, n_pos;
    logic [31:0]     r_val, n_val;
    logic [CW-1:0]   r_count, n_count;
    logic [IW-1:0]   r_rd, n_rd;     // address read in the previous cycle
    logic [IW-1:0]   r_wr, n_wr;     // address written in this walk step
    logic [IW-1:0]   r_end, n_end;   // last write address of the walk
    logic            r_up, n_up;     // walk direction: 1 for remove
    logic [1:0]      r_status, n_status;
    logic [31:0]     r_read, n_read;
    logic [IW-1:0]   r_newpos, n_newpos;

    // output register
    logic            r_out_valid, n_out_valid;
    logic [1:0]      r_o_status, n_o_status;
    logic [31:0]     r_o_read, n_o_read;
    logic [5:0]      r_o_newpos, n_o_newpos;
    logic [6:0]      r_o_count, n_o_count;

    // memory port controls
    logic                  w_rd_en;
    logic [IW-1:0]         w_rd_addr;
    logic                  w_wr_en;
    logic [IW-1:0]         w_wr_addr;
    logic [ENTRY_BITS-1:0] w_wr_data;

    // shared address step unit
    logic [IW-1:0] w_step_base;
    logic          w_step_up;
    logic [IW-1:0] w_step_sum;

    // derived views
    logic [CMPW-1:0]       w_pos_ext, w_cnt_ext;
    logic [IW-1:0]         w_pos_idx, w_cnt_idx;
    logic                  w_full;
    logic [ENTRY_BITS-1:0] w_val_ent;
    logic [63:0]           w_val_wide, w_rd_wide;
    logic [15:0]           w_cnt_wide, w_newpos_wide;

    assign w_pos_ext     = CMPW'(r_pos);
    assign w_cnt_ext     = CMPW'(r_count);
    assign w_pos_idx     = IW'(r_pos);
    assign w_cnt_idx     = IW'(r_count);
    assign w_full        = (r_count == CW'(CAPACITY));
    assign w_val_wide    = 64'(r_val);
    assign w_val_ent     = w_val_wide[ENTRY_BITS-1:0];
    assign w_rd_wide     = 64'(r_rd_data);
    assign w_cnt_wide    = 16'(r_count);
    assign w_newpos_wide = 16'(r_newpos);

    assign w_step_sum = w_step_up ? (w_step_base + 1'b1) : (w_step_base - 1'b1);

    // sequencer: next state, memory controls, register updates
    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_pos       = r_pos;
        n_val       = r_val;
        n_count     = r_count;
        n_rd        = r_rd;
        n_wr        = r_wr;
        n_end       = r_end;
        n_up        = r_up;
        n_status    = r_status;
        n_read      = r_read;
        n_newpos    = r_newpos;
        n_out_valid = r_out_valid && !i_m_tready;
        n_o_status  = r_o_status;
        n_o_read    = r_o_read;
        n_o_newpos  = r_o_newpos;
        n_o_count   = r_o_count;
        w_rd_en     = 1'b0;
        w_rd_addr   = w_step_sum;
        w_wr_en     = 1'b0;
        w_wr_addr   = r_wr;
        w_wr_data   = r_rd_data;
        w_step_base = r_rd;
        w_step_up   = r_up;

        case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    n_cmd   = t_cmd'(i_s_tdata[2:0]);
                    n_pos   = i_s_tdata[9:3];
                    n_val   = i_s_tdata[41:10];
                    n_state = S_CHECK;
                end
            end

            S_CHECK: begin
                n_status = ST_OK;
                n_read   = '0;
                n_newpos = '0;
                n_state  = S_RESULT;
                case (r_cmd)
                    CMD_GET: begin
                        if (w_pos_ext >= w_cnt_ext) begin
                            n_status = ST_RANGE;
                        end else begin
                            w_rd_en   = 1'b1;
                            w_rd_addr = w_pos_idx;
                            n_state   = S_READ;
                        end
                    end
                    CMD_SET: begin
                        if (w_pos_ext >= w_cnt_ext) begin
                            n_status = ST_RANGE;
                        end else begin
                            w_wr_en   = 1'b1;
                            w_wr_addr = w_pos_idx;
                            w_wr_data = w_val_ent;
                        end
                    end
                    CMD_ADD: begin
                        if (w_full) begin
                            n_status = ST_FULL;
                        end else begin
                            w_wr_en   = 1'b1;
                            w_wr_addr = w_cnt_idx;
                            w_wr_data = w_val_ent;
                            n_newpos  = w_cnt_idx;
                            n_count   = CW'(r_count + 1'b1);
                        end
                    end
                    CMD_INSERT: begin
                        if (w_pos_ext > w_cnt_ext) begin
                            n_status = ST_RANGE;
                        end else if (w_full) begin
                            n_status = ST_FULL;
                        end else if (w_pos_ext == w_cnt_ext) begin
                            // append at the tail, nothing to move
                            w_wr_en   = 1'b1;
                            w_wr_addr = w_pos_idx;
                            w_wr_data = w_val_ent;
                            n_count   = CW'(r_count + 1'b1);
                        end else begin
                            // walk down from the tail, first read at count-1
                            w_step_base = w_cnt_idx;
                            w_step_up   = 1'b0;
                            w_rd_en     = 1'b1;
                            n_rd        = w_step_sum;
                            n_wr        = w_cnt_idx;
                            n_end       = IW'(w_pos_idx + 1'b1);
                            n_up        = 1'b0;
                            n_state     = S_SHIFT;
                        end
                    end
                    CMD_REMOVE: begin
                        if (w_pos_ext >= w_cnt_ext) begin
                            n_status = ST_RANGE;
                        end else if (CMPW'(w_pos_ext + 1'b1) == w_cnt_ext) begin
                            // removing the tail entry
                            n_count = CW'(r_count - 1'b1);
                        end else begin
                            // walk up from position, first read at position+1
                            w_step_base = w_pos_idx;
                            w_step_up   = 1'b1;
                            w_rd_en     = 1'b1;
                            n_rd        = w_step_sum;
                            n_wr        = w_pos_idx;
                            n_end       = IW'(r_count - 2'd2);
                            n_up        = 1'b1;
                            n_state     = S_SHIFT;
                        end
                    end
                    CMD_CLEAR: begin
                        n_count = '0;
                    end
                    default: begin
                    end
                endcase
            end

            S_READ: begin
                n_read  = w_rd_wide[31:0];
                n_state = S_RESULT;
            end

            // one entry per cycle: write the word read last cycle, read the next
            S_SHIFT: begin
                w_wr_en   = 1'b1;
                w_wr_addr = r_wr;
                w_wr_data = r_rd_data;
                if (r_wr == r_end) begin
                    if (r_up) begin
                        n_count = CW'(r_count - 1'b1);
                        n_state = S_RESULT;
                    end else begin
                        n_state = S_INS_FINAL;
                    end
                end else begin
                    w_rd_en = 1'b1;
                    n_rd    = w_step_sum;
                    n_wr    = r_rd;
                end
            end

            S_INS_FINAL: begin
                w_wr_en   = 1'b1;
                w_wr_addr = w_pos_idx;
                w_wr_data = w_val_ent;
                n_count   = CW'(r_count + 1'b1);
                n_state   = S_RESULT;
            end

            // load the output register once it is free
            S_RESULT: begin
                if (!r_out_valid || i_m_tready) begin
                    n_out_valid = 1'b1;
                    n_o_status  = r_status;
                    n_o_read    = r_read;
                    n_o_newpos  = w_newpos_wide[5:0];
                    n_o_count   = w_cnt_wide[6:0];
                    n_state     = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_cmd      <= n_cmd;
        r_pos      <= n_pos;
        r_val      <= n_val;
        r_rd       <= n_rd;
        r_wr       <= n_wr;
        r_end      <= n_end;
        r_up       <= n_up;
        r_status   <= n_status;
        r_read     <= n_read;
        r_newpos   <= n_newpos;
        r_o_status <= n_o_status;
        r_o_read   <= n_o_read;
        r_o_newpos <= n_o_newpos;
        r_o_count  <= n_o_count;
    end

    // entry memory: one write, one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[w_wr_addr] <= w_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rd_en) begin
            r_rd_data <= r_mem[w_rd_addr];
        end
    end

    // ports
    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {1'b0, r_o_count, r_o_newpos, r_o_read, r_o_status};

`ifndef ASSERT_OFF
    // entry count never passes capacity
    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("entry count above capacity");

    // the entry walk never writes above the current count
    a_walk_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SHIFT) |-> (CW'(r_wr) <= r_count))
        else $error("walk writes beyond list end");

    // count moves by one, clears to zero, or holds
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (r_count == $past(r_count)
                            || r_count == CW'($past(r_count) + 1'b1)
                            || r_count == CW'($past(r_count) - 1'b1)
                            || r_count == '0))
        else $error("entry count jumped");
`endif

endmodule
